### src/wmae_pkg.sv
// shared types and constants for the windowed mean and ac energy block
// no dependencies
`default_nettype none

package wmae_pkg;

  localparam int SAMPLE_W   = 14;
  localparam int MEAN_LEN   = 16;
  localparam int ENERGY_LEN = 64;

  localparam int MEAN_SHIFT = $clog2(MEAN_LEN);
  localparam int MEAN_SUM_W = SAMPLE_W + $clog2(MEAN_LEN);
  localparam int E_SUM_W    = SAMPLE_W + $clog2(ENERGY_LEN);
  localparam int SQ_W       = 2 * SAMPLE_W;
  localparam int E_SQ_W     = SQ_W + $clog2(ENERGY_LEN);

  localparam int MEAN_W     = 22;
  localparam int ENERGY_W   = 50;
  localparam int FRAC_W     = 8;

  localparam logic [SAMPLE_W-1:0] THR_RESET = 14'd4095;

  typedef enum logic [0:0] {
    CMD_ADD    = 1'b0,
    CMD_SET_OK = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [MEAN_SUM_W-1:0] smean;
    logic [E_SUM_W-1:0]    s1;
    logic [E_SQ_W-1:0]     s2;
    logic                  ok;
  } snap_t;

endpackage

`default_nettype wire

### src/wmae_window.sv
// delay lines, running window sums and the sticky data valid flag
// depends on wmae_pkg
`default_nettype none

module wmae_window (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           apply,
  input  wmae_pkg::cmd_t                 cmd,
  input  logic [wmae_pkg::SAMPLE_W-1:0]  smp,
  input  logic [wmae_pkg::SAMPLE_W-1:0]  threshold,
  output wmae_pkg::snap_t                snap
);
  import wmae_pkg::*;

  logic [SAMPLE_W-1:0]   mean_line [MEAN_LEN];
  logic [SAMPLE_W-1:0]   energy_line [ENERGY_LEN];
  logic [MEAN_SUM_W-1:0] smean;
  logic [E_SUM_W-1:0]    s1;
  logic [E_SQ_W-1:0]     s2;
  logic                  ok;

  logic [MEAN_SUM_W-1:0] smean_next;
  logic [E_SUM_W-1:0]    s1_next;
  logic [E_SQ_W-1:0]     s2_next;
  logic [SAMPLE_W-1:0]   old_e;
  logic [SQ_W-1:0]       sq_new;
  logic [SQ_W-1:0]       sq_old;

  always_comb begin
    old_e      = energy_line[ENERGY_LEN-1];
    sq_new     = SQ_W'(smp) * SQ_W'(smp);
    sq_old     = SQ_W'(old_e) * SQ_W'(old_e);
    smean_next = smean + MEAN_SUM_W'(smp) - MEAN_SUM_W'(mean_line[MEAN_LEN-1]);
    s1_next    = s1 + E_SUM_W'(smp) - E_SUM_W'(old_e);
    s2_next    = s2 + E_SQ_W'(sq_new) - E_SQ_W'(sq_old);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MEAN_LEN; i++) mean_line[i] <= '0;
      for (int i = 0; i < ENERGY_LEN; i++) energy_line[i] <= '0;
      smean <= '0;
      s1    <= '0;
      s2    <= '0;
      ok    <= 1'b1;
    end else if (apply) begin
      unique case (cmd)
        CMD_SET_OK: begin
          ok <= 1'b1;
        end
        CMD_ADD: begin
          for (int i = MEAN_LEN - 1; i > 0; i--) mean_line[i] <= mean_line[i-1];
          mean_line[0] <= smp;
          for (int i = ENERGY_LEN - 1; i > 0; i--) energy_line[i] <= energy_line[i-1];
          energy_line[0] <= smp;
          smean <= smean_next;
          s1    <= s1_next;
          s2    <= s2_next;
          if (smp > threshold) begin
            ok <= 1'b0;
          end
        end
        default: begin
          ok <= ok;
        end
      endcase
    end
  end

  assign snap = '{smean: smean, s1: s1, s2: s2, ok: ok};

endmodule

`default_nettype wire

### src/wmae_energy.sv
// mean and energy datapath: product stage and result register
// depends on wmae_pkg
`default_nettype none

module wmae_energy (
  input  logic                          clk,
  input  logic                          load_prod,
  input  logic                          load_out,
  input  wmae_pkg::snap_t               snap,
  output logic [wmae_pkg::MEAN_W-1:0]   mean_value,
  output logic [wmae_pkg::ENERGY_W-1:0] energy_value,
  output logic                          data_ok
);
  import wmae_pkg::*;

  localparam int MS_W  = MEAN_W + E_SUM_W;
  localparam int MM_W  = 2 * MEAN_W;
  localparam int ACC_W = ENERGY_W + 3;
  localparam int SHIFTED_W = MEAN_SUM_W + FRAC_W;
  localparam logic [ACC_W-1:0] LEN_K = ACC_W'(ENERGY_LEN);

  logic [SHIFTED_W-1:0] mean_full;
  logic [MEAN_W-1:0]    mean_c;

  logic [MEAN_W-1:0]    m_q;
  logic [MS_W-1:0]      p_ms;
  logic [MM_W-1:0]      p_mm;
  logic [E_SQ_W-1:0]    s2_q;
  logic                 ok_q;

  logic [ACC_W-1:0]     acc;

  // power-of-two window: the division is a shift
  always_comb begin
    mean_full = {snap.smean, {FRAC_W{1'b0}}} >> MEAN_SHIFT;
    mean_c    = mean_full[MEAN_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (load_prod) begin
      m_q  <= mean_c;
      p_ms <= MS_W'(mean_c) * MS_W'(snap.s1);
      p_mm <= MM_W'(mean_c) * MM_W'(mean_c);
      s2_q <= snap.s2;
      ok_q <= snap.ok;
    end
  end

  // 2^16*sum(x^2) - 2^9*m*sum(x) + n*m^2
  always_comb begin
    acc = (ACC_W'(s2_q) << 16) - (ACC_W'(p_ms) << 9) + ACC_W'(p_mm) * LEN_K;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      mean_value   <= m_q;
      energy_value <= acc[ENERGY_W-1:0];
      data_ok      <= ok_q;
    end
  end

endmodule

`default_nettype wire

### src/windowed_mean_and_ac_energy.sv
// top level: input register, window state, product stage, result register
// depends on wmae_pkg, wmae_window, wmae_energy
`default_nettype none

// Takes one item per clock cycle unless the result waits. A result passes the input
// register, window update, product register and result register after its transfer;
// the four stages stall in place while the result waits, with bubbles squeezed out.
// The rate is set by the running sums over the two windows, updated once per sample.
// The mean is the short-window sum scaled to Q14.8; the energy is formed from the
// long-window sums of samples and squares with two multipliers after the sums.
// The threshold register may be written only while no item is in flight.
module windowed_mean_and_ac_energy (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  logic                          command,
  input  logic [wmae_pkg::SAMPLE_W-1:0] sample,
  output logic                          result_valid,
  input  logic                          result_ready,
  output logic [wmae_pkg::MEAN_W-1:0]   mean_value,
  output logic [wmae_pkg::ENERGY_W-1:0] energy_value,
  output logic                          data_ok,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wmae_pkg::SAMPLE_W-1:0] fault_threshold
);
  import wmae_pkg::*;

  logic [SAMPLE_W-1:0] threshold;
  cmd_t                cmd0;
  logic [SAMPLE_W-1:0] smp0;
  logic                v0, v1, v2, v3;
  logic                ld0, ld1, ld2, ld3;
  logic                apply;
  snap_t               snap;

  assign ld3          = !v3 || result_ready;
  assign ld2          = !v2 || ld3;
  assign ld1          = !v1 || ld2;
  assign ld0          = !v0 || ld1;
  assign apply        = v0 && ld1;
  assign item_ready   = ld0;
  assign result_valid = v3;
  assign cfg_ready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_valid) begin
      threshold <= fault_threshold;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (ld0) v0 <= item_valid;
      if (ld1) v1 <= v0;
      if (ld2) v2 <= v1;
      if (ld3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ld0 && item_valid) begin
      cmd0 <= cmd_t'(command);
      smp0 <= sample;
    end
  end

  wmae_window u_window (
    .clk       (clk),
    .rst       (rst),
    .apply     (apply),
    .cmd       (cmd0),
    .smp       (smp0),
    .threshold (threshold),
    .snap      (snap)
  );

  wmae_energy u_energy (
    .clk          (clk),
    .load_prod    (v1 && ld2),
    .load_out     (v2 && ld3),
    .snap         (snap),
    .mean_value   (mean_value),
    .energy_value (energy_value),
    .data_ok      (data_ok)
  );

`ifndef ASSERT_OFF
  // a clear transfer leaves the flag set
  a_clear_sets_ok: assert property (@(posedge clk) disable iff (rst)
    apply && cmd0 == CMD_SET_OK |=> snap.ok)
    else $error("data valid flag not set after clear");

  // window state holds while its snapshot waits for the product stage
  a_state_holds: assert property (@(posedge clk) disable iff (rst)
    v1 && !ld2 |=> $stable(snap.s2) && $stable(snap.s1) && $stable(snap.smean))
    else $error("window state changed under a stalled snapshot");

  // an all-zero long window has no squared sum
  a_sums_agree: assert property (@(posedge clk) disable iff (rst)
    snap.s1 == '0 |-> snap.s2 == '0)
    else $error("running sums disagree");
`endif

endmodule

`default_nettype wire
